@@ hdl/ascii85_stream_decoder_core_defines.svh @@
// Assertion macros for the ascii85 stream decoder core.
`ifndef ASCII85_STREAM_DECODER_CORE_DEFINES_SVH
`define ASCII85_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define A85_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("a85 check failed");
`define A85_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("a85 check failed");
`else
`define A85_ASSERT_IMPL(lbl, ante, cons)
`define A85_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/a85_pkg.sv @@
package a85_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCw    = 3;

  localparam logic        KindText   = 1'b0;
  localparam logic        KindEnd    = 1'b1;

  localparam logic [1:0]  StatByte   = 2'd0;
  localparam logic [1:0]  StatEndOk  = 2'd1;
  localparam logic [1:0]  StatEndErr = 2'd2;

  localparam logic [7:0]  ChFirst    = 8'd33;   // '!'
  localparam logic [7:0]  ChLastDig  = 8'd117;  // 'u'
  localparam logic [7:0]  ChZero     = 8'd122;  // 'z'
  localparam logic [7:0]  ChSpace    = 8'd32;
  localparam logic [7:0]  ChTab      = 8'd9;
  localparam logic [7:0]  ChCr       = 8'd13;

  localparam logic [2:0]  GroupDigits = 3'd5;
  localparam logic [2:0]  BytesFull   = 3'd4;

  localparam logic [31:0] Pow85_1 = 32'd85;
  localparam logic [31:0] Pow85_2 = 32'd7225;
  localparam logic [31:0] Pow85_3 = 32'd614125;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // one queued job: up to four bytes, optionally followed by an end status
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  nbytes;
    logic        is_end;
    logic [1:0]  end_status;
  } job_t;

endpackage

@@ hdl/a85_front.sv @@
module a85_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  a85_pkg::in_word_t in_word_i,
  input  logic             q_full_i,
  output logic             push_o,
  output a85_pkg::job_t    job_o
);
  import a85_pkg::*;

  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] val_q, val_d;
  logic        azg_q, azg_d;
  logic        failed_q, failed_d;

  logic        in_acc;
  logic [6:0]  dig;
  logic [31:0] val_step;
  logic [31:0] pad_mul;
  logic [31:0] val_pad;
  logic [2:0]  cnt_inc;

  assign in_ready_o = !q_full_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign dig      = 7'(in_word_i.symbol - ChFirst);
  assign val_step = 32'(val_q * Pow85_1) + 32'(dig);
  assign cnt_inc  = 3'(cnt_q + 3'd1);

  // tail padded with 'u' digits: v*85^k + 85^k - 1
  always_comb begin
    case (cnt_q)
      3'd2:    pad_mul = Pow85_3;
      3'd3:    pad_mul = Pow85_2;
      default: pad_mul = Pow85_1;
    endcase
  end
  assign val_pad = 32'(val_q * pad_mul) + 32'(pad_mul - 32'd1);

  always_comb begin
    cnt_d    = cnt_q;
    val_d    = val_q;
    azg_d    = azg_q;
    failed_d = failed_q;
    push_o   = 1'b0;
    job_o    = '0;
    if (in_acc) begin
      if (in_word_i.kind == KindEnd) begin
        push_o           = 1'b1;
        job_o.is_end     = 1'b1;
        job_o.end_status = StatEndOk;
        if (failed_q || cnt_q == 3'd1) begin
          job_o.end_status = StatEndErr;
        end else if (cnt_q >= 3'd2) begin
          job_o.value  = val_pad;
          job_o.nbytes = 3'(cnt_q - 3'd1);
        end
        cnt_d    = '0;
        val_d    = '0;
        azg_d    = 1'b0;
        failed_d = 1'b0;
      end else if (!failed_q) begin
        if (in_word_i.symbol inside {[ChTab:ChCr], ChSpace}) begin
          // whitespace
        end else if (in_word_i.symbol == ChZero) begin
          if (cnt_q != 3'd0 || azg_q) begin
            failed_d = 1'b1;
          end else begin
            push_o       = 1'b1;
            job_o.nbytes = BytesFull;
            azg_d        = 1'b1;
          end
        end else if (in_word_i.symbol inside {[ChFirst:ChLastDig]}) begin
          azg_d = 1'b0;
          if (cnt_inc == GroupDigits) begin
            push_o       = 1'b1;
            job_o.value  = val_step;
            job_o.nbytes = BytesFull;
            cnt_d        = '0;
            val_d        = '0;
          end else begin
            cnt_d = cnt_inc;
            val_d = val_step;
          end
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      val_q    <= '0;
      azg_q    <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      val_q    <= val_d;
      azg_q    <= azg_d;
      failed_q <= failed_d;
    end
  end

endmodule

@@ hdl/a85_queue.sv @@
module a85_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  a85_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output a85_pkg::job_t head_o
);
  import a85_pkg::*;

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0] cnt_q;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QAw'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QAw'(rd_ptr_q + 1'b1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= QCw'(cnt_q + 1'b1);
        2'b01:   cnt_q <= QCw'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hdl/a85_back.sv @@
module a85_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  a85_pkg::job_t     q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output a85_pkg::out_word_t out_word_o
);
  import a85_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, word;
  logic       load;
  logic       in_bytes;
  logic [1:0] sel;

  assign load     = q_valid_i && (!out_valid_q || out_ready_i);
  assign in_bytes = ({1'b0, idx_q} < q_head_i.nbytes);
  assign sel      = 2'(2'd3 - idx_q);

  always_comb begin
    word = '0;
    if (in_bytes) begin
      word.data_byte = q_head_i.value[{sel, 3'b000} +: 8];
      word.status    = StatByte;
      word.last      = ({1'b0, idx_q} == 3'(q_head_i.nbytes - 3'd1)) && !q_head_i.is_end;
    end else begin
      word.status = q_head_i.end_status;
      word.last   = 1'b1;
    end
  end

  assign pop_o = load && word.last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = word.last ? 2'd0 : 2'(idx_q + 2'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hdl/ascii85_stream_decoder_core.sv @@
// Channel   Handshake               Payload
// in        in_valid_i/in_ready_o   in_word_i  {kind, symbol}
// out       out_valid_o/out_ready_i out_word_o {data_byte, status, last}
//
// Front takes one input word per cycle while the 4-entry job queue has room.
// Back sends one output word per cycle while out_ready_i is high; a full group or 'z'
// yields 4 output words, an end word 1 to 4, so a stream of groups runs at the output rate.
// Decode, including the 32x32 tail padding multiply, is combinational in front.
// Async reset clears counters, flags and queue pointers; no clearing pass.
`include "ascii85_stream_decoder_core_defines.svh"

module ascii85_stream_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  a85_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output a85_pkg::out_word_t out_word_o
);
  import a85_pkg::*;

  logic  push, pop, q_full, q_valid;
  job_t  job, q_head;
  logic  in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  a85_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  a85_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  a85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `A85_ASSERT_IMPL(a_no_overflow, q_full, !push)
  `A85_ASSERT_IMPL(a_end_pushes, in_acc && in_word_i.kind == KindEnd, push)
  `A85_ASSERT_IMPL(a_status_last, out_valid_o && out_word_o.status != StatByte, out_word_o.last)
  `A85_ASSERT_NEXT(a_pop_last, pop, out_valid_o && out_word_o.last)

endmodule
